// ----- rtl/fss_pkg.sv -----
// ----------------------------------------------------------------------------
// fss_pkg
// Shared widths, codes and types of the formant sample synthesizer.
// ----------------------------------------------------------------------------
package fss_pkg;

  // field widths
  localparam int PITCH_W   = 16;
  localparam int MODE_W    = 2;
  localparam int GAIN_W    = 16;
  localparam int COEF_W    = 24;
  localparam int DATA_W    = 32;
  localparam int SRC_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int FB_ONE_W  = 22;
  localparam int FB_TWO_W  = 21;

  // resonator chain: glottal cell then three formant cells
  localparam int NUM_CELLS = 4;

  localparam int SAMPLE_RATE_DEFAULT = 22050;

  // source mode codes
  localparam logic [MODE_W-1:0] MODE_SILENT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VOICED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NOISE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GLOTTAL_FB_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOTTAL_FB_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED     = 2'd2;

  // Q20 unity input coefficient of the glottal resonator
  localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sd1048576;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cell_status_t;

  typedef struct packed {
    logic                    done;
    logic signed [SRC_W-1:0] value;
  } src_result_t;

  typedef struct packed {
    logic              load;
    logic [DATA_W-1:0] value;
  } seed_load_t;

endpackage

// ----- rtl/fss_source.sv -----
// ----------------------------------------------------------------------------
// fss_source
// Excitation source: Q24 pitch phase pulse train, scaled xorshift32 noise or
// silence, built over a four step sequencer after each start pulse.
// ----------------------------------------------------------------------------
module fss_source #(
  parameter int SAMPLE_RATE = fss_pkg::SAMPLE_RATE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [fss_pkg::MODE_W-1:0]   mode,
  input  logic [fss_pkg::PITCH_W-1:0]  pitch,
  input  logic [fss_pkg::GAIN_W-1:0]   gain,
  input  fss_pkg::seed_load_t          seed,
  output fss_pkg::src_result_t         res,
  output logic                         busy
);
  import fss_pkg::*;

  // pitch step is (pitch << STEP_FRAC) / SAMPLE_RATE
  localparam int STEP_FRAC = 16;
  localparam int RECIP_W   = 20;
  localparam int STEP_W    = 20;
  localparam int RATE_W    = 16;
  localparam int PPROD_W   = PITCH_W + RECIP_W;
  localparam int QBACK_W   = STEP_W + RATE_W;
  localparam int PHASE_W   = 24;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << (2 * STEP_FRAC)) / SAMPLE_RATE);
  localparam logic [RATE_W-1:0]  RATE = RATE_W'(SAMPLE_RATE);

  // pulse train constants
  localparam logic [PHASE_W-1:0]     EARLY_LIMIT = 24'd1006632;
  localparam logic signed [SRC_W-1:0] PULSE_HIGH = 20'sd3000;
  localparam logic signed [SRC_W-1:0] PULSE_LOW  = -20'sd750;

  // noise scaling: divide by 40 through a Q21 reciprocal
  localparam int                 MAG_W       = 16;
  localparam logic [MAG_W-1:0]   DIV40_RECIP = 16'd52429;
  localparam int                 DIV40_SHIFT = 21;
  localparam int                 NQ_W        = 11;
  localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 16'd256;
  localparam int                 GPROD_W     = NQ_W + GAIN_W + 1;

  // sequencer steps
  localparam logic [1:0] ST_SCALE   = 2'd0;
  localparam logic [1:0] ST_CORRECT = 2'd1;
  localparam logic [1:0] ST_GAIN    = 2'd2;
  localparam logic [1:0] ST_FINISH  = 2'd3;

  logic [1:0]               state;
  logic [PHASE_W-1:0]       phase;
  logic [DATA_W-1:0]        noise_state;
  logic                     done;
  logic signed [SRC_W-1:0]  src_value;

  logic [PPROD_W-1:0]       pitch_prod;
  logic [DATA_W-1:0]        draw;
  logic [STEP_W-1:0]        q_est;
  logic [QBACK_W-1:0]       q_back;
  logic [DATA_W-1:0]        noise_prod;
  logic [STEP_W-1:0]        step_val;
  logic signed [NQ_W-1:0]   noise_base;
  logic signed [GPROD_W-1:0] gain_prod;
  logic [PHASE_W:0]         phase_sum;

  logic [DATA_W-1:0]        xs1;
  logic [DATA_W-1:0]        xs2;
  logic [DATA_W-1:0]        xs3;
  logic                     draw_neg;
  logic [MAG_W-1:0]         mag;
  logic [NQ_W-1:0]          nq;
  logic [QBACK_W-1:0]       rem;
  logic                     bump;
  logic                     gain_unity;
  logic signed [SRC_W-1:0]  noise_src;
  logic [PHASE_W-1:0]       phase_new;
  logic signed [SRC_W-1:0]  pulse;

  // xorshift32 draw
  always_comb begin
    xs1 = noise_state ^ (noise_state << 13);
    xs2 = xs1 ^ (xs1 >> 17);
    xs3 = xs2 ^ (xs2 << 5);
  end

  // magnitude of the centered low half of the draw
  always_comb begin
    draw_neg = ~draw[15];
    if (draw_neg) begin
      mag = MAG_W'(17'd32768 - {2'b00, draw[14:0]});
    end else begin
      mag = {1'b0, draw[14:0]};
    end
    nq = noise_prod[DATA_W-1:DIV40_SHIFT];
  end

  // quotient correction, gain and pulse selection
  always_comb begin
    rem        = QBACK_W'({pitch, {STEP_FRAC{1'b0}}}) - q_back;
    bump       = rem >= QBACK_W'(RATE);
    gain_unity = (gain == '0) || (gain == GAIN_UNITY);
    if (gain_unity) begin
      noise_src = SRC_W'(noise_base);
    end else begin
      noise_src = gain_prod[GPROD_W-1:8];
    end
    if (phase_sum[PHASE_W]) begin
      phase_new = phase_sum[PHASE_W-1:0];
      pulse     = PULSE_HIGH;
    end else begin
      phase_new = phase_sum[PHASE_W-1:0];
      pulse     = (phase_sum[PHASE_W-1:0] < EARLY_LIMIT) ? PULSE_LOW : '0;
    end
  end

  // sequencer and source state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      done        <= 1'b0;
      state       <= ST_SCALE;
      phase       <= '0;
      noise_state <= 32'd1;
    end else begin
      done <= 1'b0;
      if (seed.load) begin
        noise_state <= (seed.value == '0) ? 32'd1 : seed.value;
      end
      if (go) begin
        busy  <= 1'b1;
        state <= ST_SCALE;
      end else if (busy) begin
        unique case (state)
          ST_SCALE:   state <= ST_CORRECT;
          ST_CORRECT: state <= ST_GAIN;
          ST_GAIN:    state <= ST_FINISH;
          ST_FINISH: begin
            busy <= 1'b0;
            done <= 1'b1;
            state <= ST_SCALE;
            case (mode)
              MODE_SILENT: ;
              MODE_VOICED: phase <= phase_new;
              default:     noise_state <= draw;
            endcase
          end
          default: state <= ST_SCALE;
        endcase
      end
    end
  end

  // datapath registers of the start and the sequencer steps
  always_ff @(posedge clk) begin
    if (go) begin
      pitch_prod <= PPROD_W'(pitch) * PPROD_W'(RECIP);
      draw       <= xs3;
    end else if (busy) begin
      unique case (state)
        ST_SCALE: begin
          q_est      <= pitch_prod[PPROD_W-1:STEP_FRAC];
          q_back     <= QBACK_W'(pitch_prod[PPROD_W-1:STEP_FRAC]) * QBACK_W'(RATE);
          noise_prod <= DATA_W'(mag) * DATA_W'(DIV40_RECIP);
        end
        ST_CORRECT: begin
          step_val   <= bump ? (q_est + 1'b1) : q_est;
          noise_base <= draw_neg ? -$signed(nq) : $signed(nq);
        end
        ST_GAIN: begin
          gain_prod <= GPROD_W'(noise_base) * GPROD_W'($signed({1'b0, gain}));
          phase_sum <= {1'b0, phase} + (PHASE_W + 1)'(step_val);
        end
        ST_FINISH: begin
          case (mode)
            MODE_SILENT: src_value <= '0;
            MODE_VOICED: src_value <= pulse;
            default:     src_value <= noise_src;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign res.done  = done;
  assign res.value = src_value;

endmodule

// ----- rtl/fss_cell.sv -----
// ----------------------------------------------------------------------------
// fss_cell
// Two-pole resonator cell: y = (a*x + b*y1 + c*y2) >> 20 with one shared
// multiplier taking the three products in turn, result handed to the next cell.
// ----------------------------------------------------------------------------
module fss_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [fss_pkg::DATA_W-1:0] x_in,
  input  fss_pkg::coef_t                    coef,
  output logic signed [fss_pkg::DATA_W-1:0] y,
  output fss_pkg::cell_status_t             status
);
  import fss_pkg::*;

  localparam int QBITS  = 20;
  localparam int ACC_W  = DATA_W + QBITS;
  localparam int PROD_W = COEF_W + DATA_W;

  logic                     busy;
  logic                     step;
  logic                     done;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] y1;
  logic signed [DATA_W-1:0] y2;

  logic signed [COEF_W-1:0] mcoef;
  logic signed [DATA_W-1:0] mop;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum;

  // operand selection for the shared multiplier
  always_comb begin
    if (start) begin
      mcoef = coef.a;
      mop   = x_in;
    end else if (!step) begin
      mcoef = coef.b;
      mop   = y1;
    end else begin
      mcoef = coef.c;
      mop   = y2;
    end
    prod = mcoef * mop;
    sum  = (start ? '0 : acc) + prod[ACC_W-1:0];
  end

  // step control and history
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 1'b0;
      done <= 1'b0;
      y1   <= '0;
      y2   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 1'b0;
      end else if (busy) begin
        if (!step) begin
          step <= 1'b1;
        end else begin
          busy <= 1'b0;
          step <= 1'b0;
          done <= 1'b1;
          y2   <= y1;
          y1   <= sum[ACC_W-1:QBITS];
        end
      end
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (start || busy) begin
      acc <= sum;
    end
  end

  assign y           = y1;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ----- rtl/formant_synth_sample_top.sv -----
// ----------------------------------------------------------------------------
// formant_synth_sample_top
// Cascade formant synthesizer, one output sample per frame item: excitation
// source, glottal resonator for voiced items, three formant resonators and a first difference.
// ----------------------------------------------------------------------------
//
//   channel | handshake                  | payload
//   --------+----------------------------+----------------------------------
//   frame   | frame_valid / frame_stall  | pitch, mode, gain, 9 coefficients
//   sample  | sample_valid / sample_stall| sample_out
//   cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// An item passes from accept through the start, the source sequencer steps,
// the glottal cell (voiced items only), each formant cell on its single
// multiplier, the pending flag for the finished result and the load into the
// output register; the next item is accepted only after that load.
// Reset clears all history, the phase and the noise state (to one) at once.
// The finished sample waits in the output register under sample_stall while
// the next item is accepted; a second result holds in the last cell and
// keeps frame_stall high until the output register frees.
//
module formant_synth_sample_top #(
  parameter int SAMPLE_RATE = fss_pkg::SAMPLE_RATE_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 frame_valid,
  output logic                                 frame_stall,
  input  logic [fss_pkg::PITCH_W-1:0]          pitch_q8,
  input  logic [fss_pkg::MODE_W-1:0]           source_mode,
  input  logic [fss_pkg::GAIN_W-1:0]           noise_gain_q8,
  input  logic signed [fss_pkg::COEF_W-1:0]    res1_input_gain,
  input  logic signed [fss_pkg::COEF_W-1:0]    res1_fb_one,
  input  logic signed [fss_pkg::COEF_W-1:0]    res1_fb_two,
  input  logic signed [fss_pkg::COEF_W-1:0]    res2_input_gain,
  input  logic signed [fss_pkg::COEF_W-1:0]    res2_fb_one,
  input  logic signed [fss_pkg::COEF_W-1:0]    res2_fb_two,
  input  logic signed [fss_pkg::COEF_W-1:0]    res3_input_gain,
  input  logic signed [fss_pkg::COEF_W-1:0]    res3_fb_one,
  input  logic signed [fss_pkg::COEF_W-1:0]    res3_fb_two,
  output logic                                 sample_valid,
  input  logic                                 sample_stall,
  output logic signed [fss_pkg::DATA_W-1:0]    sample_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fss_pkg::DATA_W-1:0]           cfg_data
);
  import fss_pkg::*;

  logic                       cfg_write;
  logic [FB_ONE_W-1:0]        glottal_fb_one;
  logic signed [FB_TWO_W-1:0] glottal_fb_two;
  seed_load_t                 seed;

  logic                       accept;
  logic                       busy;
  logic                       go;
  logic                       pending;
  logic                       out_load;
  logic signed [DATA_W-1:0]   last_filtered;

  logic [PITCH_W-1:0]         pitch_r;
  logic [MODE_W-1:0]          mode_r;
  logic [GAIN_W-1:0]          gain_r;
  coef_t                      formant_coef [NUM_CELLS-1];
  logic                       voiced;

  src_result_t                src_res;
  logic                       src_busy;

  logic                       cell_start  [NUM_CELLS];
  logic signed [DATA_W-1:0]   cell_x      [NUM_CELLS];
  logic signed [DATA_W-1:0]   cell_y      [NUM_CELLS];
  coef_t                      cell_coef   [NUM_CELLS];
  cell_status_t               cell_status [NUM_CELLS];
  logic [NUM_CELLS:0]         stage_busy;

  // handshakes
  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign frame_stall = busy;
  assign accept      = frame_valid && !frame_stall;
  assign out_load    = pending && (!sample_valid || !sample_stall);
  assign voiced      = (mode_r == MODE_VOICED);

  assign seed.load  = cfg_write && (cfg_index == CFG_NOISE_SEED);
  assign seed.value = cfg_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      glottal_fb_one <= '0;
      glottal_fb_two <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GLOTTAL_FB_ONE: glottal_fb_one <= cfg_data[FB_ONE_W-1:0];
        CFG_GLOTTAL_FB_TWO: glottal_fb_two <= $signed(cfg_data[FB_TWO_W-1:0]);
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      pitch_r         <= pitch_q8;
      mode_r          <= source_mode;
      gain_r          <= noise_gain_q8;
      formant_coef[0] <= '{a: res1_input_gain, b: res1_fb_one, c: res1_fb_two};
      formant_coef[1] <= '{a: res2_input_gain, b: res2_fb_one, c: res2_fb_two};
      formant_coef[2] <= '{a: res3_input_gain, b: res3_fb_one, c: res3_fb_two};
    end
  end

  // item control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      go            <= 1'b0;
      pending       <= 1'b0;
      sample_valid  <= 1'b0;
      last_filtered <= '0;
    end else begin
      go <= accept;
      if (accept) begin
        busy <= 1'b1;
      end
      if (cell_status[NUM_CELLS-1].done) begin
        pending <= 1'b1;
      end
      if (out_load) begin
        pending       <= 1'b0;
        busy          <= 1'b0;
        sample_valid  <= 1'b1;
        last_filtered <= cell_y[NUM_CELLS-1];
      end else if (sample_valid && !sample_stall) begin
        sample_valid <= 1'b0;
      end
    end
  end

  // lip radiation difference
  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= cell_y[NUM_CELLS-1] - last_filtered;
    end
  end

  // excitation source
  fss_source #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_source (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .mode  (mode_r),
    .pitch (pitch_r),
    .gain  (gain_r),
    .seed  (seed),
    .res   (src_res),
    .busy  (src_busy)
  );

  // chain wiring: glottal cell runs only in voiced mode
  always_comb begin
    cell_coef[0] = '{a: COEF_ONE,
                     b: COEF_W'({1'b0, glottal_fb_one}),
                     c: COEF_W'(glottal_fb_two)};
    cell_start[0] = src_res.done && voiced;
    cell_x[0]     = DATA_W'(src_res.value);
    cell_start[1] = cell_status[0].done || (src_res.done && !voiced);
    cell_x[1]     = voiced ? cell_y[0] : DATA_W'(src_res.value);
    for (int i = 1; i < NUM_CELLS; i++) begin
      cell_coef[i] = formant_coef[i-1];
    end
    for (int i = 2; i < NUM_CELLS; i++) begin
      cell_start[i] = cell_status[i-1].done;
      cell_x[i]     = cell_y[i-1];
    end
  end

  // resonator cells
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    fss_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .start  (cell_start[g]),
      .x_in   (cell_x[g]),
      .coef   (cell_coef[g]),
      .y      (cell_y[g]),
      .status (cell_status[g])
    );
  end

  // activity of source and cells for checking
  always_comb begin
    stage_busy[NUM_CELLS] = src_busy;
    for (int i = 0; i < NUM_CELLS; i++) begin
      stage_busy[i] = cell_status[i].busy;
    end
  end

  // at most one stage of the chain works on an item at a time
  a_one_stage: assert property (@(posedge clk) disable iff (rst)
    $onehot0(stage_busy))
    else $error("more than one chain stage active");

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after accept");

  // a result is loaded only for an item in flight
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    out_load |-> busy && !src_busy)
    else $error("output load with no item in flight");

  // a new result never arrives while the previous one is still pending
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cell_status[NUM_CELLS-1].done |-> !pending)
    else $error("result overrun in last cell");

endmodule
